// File: rtl/spiq_pkg.sv
// Shared types and codes of the sorted-insert priority queue.
package spiq_pkg;

    localparam int SYM_W = 8;
    localparam int PRI_W = 8;
    localparam int OCC_W = 5;

    localparam logic FUNC_INSERT = 1'b0;
    localparam logic FUNC_SHOW   = 1'b1;

    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_DROPPED = 2'd1;
    localparam logic [1:0] STATUS_EMPTY   = 2'd2;

    typedef struct packed {
        logic             func;
        logic [SYM_W-1:0] symbol;
        logic [PRI_W-1:0] priority_req;
    } req_t;

    typedef struct packed {
        logic [SYM_W-1:0] out_symbol;
        logic [PRI_W-1:0] out_priority;
        logic [1:0]       status;
        logic [OCC_W-1:0] occupancy;
        logic             last;
    } rsp_t;

    typedef struct packed {
        logic [SYM_W-1:0] sym;
        logic [PRI_W-1:0] pri;
    } entry_t;

    // Broadcast from the controller to every cell of the row.
    typedef struct packed {
        logic   insert;
        logic   rotate;
        entry_t new_entry;
    } cell_ctrl_t;

endpackage

// File: rtl/spiq_chan_if.sv
// Valid/ready channel carrying one payload of a given type.
interface spiq_chan_if #(parameter type payload_t = logic);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// File: rtl/spiq_cell.sv
// One storage cell of the sorted row: holds an entry, shifts right on insert, left on rotate.
module spiq_cell (
    input  logic                clk,
    input  spiq_pkg::cell_ctrl_t ctrl,
    input  logic                occupied,
    input  logic                is_tail,
    input  logic                prev_gt,
    input  spiq_pkg::entry_t    prev_entry,
    input  spiq_pkg::entry_t    next_entry,
    input  spiq_pkg::entry_t    head_entry,
    output spiq_pkg::entry_t    entry,
    output logic                gt
);

    spiq_pkg::entry_t entry_reg;
    spiq_pkg::entry_t entry_next;

    // An empty cell counts as greater, so the first empty cell takes a new largest entry.
    assign gt    = !occupied || (entry_reg.pri > ctrl.new_entry.pri);
    assign entry = entry_reg;

    always_comb
    begin
        entry_next = entry_reg;
        if (ctrl.insert && gt)
        begin
            entry_next = prev_gt ? prev_entry : ctrl.new_entry;
        end
        else if (ctrl.rotate)
        begin
            entry_next = is_tail ? head_entry : next_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule

// File: rtl/sorted_insert_priority_queue.sv
// Top level of the sorted-insert priority queue: controller, row of cells, result register.
//
// Requests arrive on req (valid/ready); results leave on rsp (valid/ready). A request is
// taken at a clock edge where valid and ready are both high.
// An insert (func 0) is placed into a row of CAPACITY cells: every cell compares its
// priority with the new one, and cells past the insertion point shift one place right,
// so equal priorities keep their arrival order. Its single result is written to the
// result register as the request is accepted. An insert into a full queue is dropped
// and reported with status dropped.
// A show (func 1) streams the stored entries in ascending priority, one per cycle while
// the receiver keeps up; the first entry is loaded into the result register from the
// show state, and the last carries last = 1. The row rotates by one place per emitted
// entry and is back in order when the show ends. A show of a non-empty queue keeps the
// input closed until its last entry has been emitted.
// Inserts sustain one per cycle while the receiver keeps up.
// If the receiver stalls, the result register holds its value and the block stops taking
// requests and stops rotating until the result is taken.
// Reset (rst_n low, asynchronous) empties the queue; cell contents are not cleared.
module sorted_insert_priority_queue #(
    parameter int CAPACITY = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    spiq_chan_if.sink     req,
    spiq_chan_if.source   rsp
);

    localparam int CNT_W = $clog2(CAPACITY + 1);

    typedef enum logic {
        ST_IDLE,
        ST_SHOW
    } state_t;

    state_t              state_reg, state_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [CNT_W-1:0]    show_idx_reg, show_idx_next;
    logic                rsp_valid_reg, rsp_valid_next;
    spiq_pkg::rsp_t      rsp_data_reg, rsp_data_next;

    spiq_pkg::req_t      req_data;
    spiq_pkg::cell_ctrl_t ctrl;
    spiq_pkg::entry_t    cell_entry [CAPACITY];
    logic                cell_gt    [CAPACITY];

    logic out_free;
    logic accept;
    logic full;
    logic show_emit;
    logic show_last;

    assign req_data  = req.payload;
    assign out_free  = !rsp_valid_reg || rsp.ready;
    assign req.ready = (state_reg == ST_IDLE) && out_free;
    assign accept    = req.valid && req.ready;
    assign full      = (count_reg == CNT_W'(CAPACITY));
    assign show_emit = (state_reg == ST_SHOW) && out_free;
    assign show_last = (show_idx_reg == count_reg - CNT_W'(1));

    assign ctrl.insert        = accept && (req_data.func == spiq_pkg::FUNC_INSERT) && !full;
    assign ctrl.rotate        = show_emit;
    assign ctrl.new_entry.sym = req_data.symbol;
    assign ctrl.new_entry.pri = req_data.priority_req;

    // The row of cells. Occupied cells form a prefix of the row, so the compare results
    // step from "not greater" to "greater" at most once, at the insertion point.
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic             prev_gt_w;
        spiq_pkg::entry_t prev_entry_w;
        spiq_pkg::entry_t next_entry_w;

        if (i == 0)
        begin : g_first
            assign prev_gt_w    = 1'b0;
            assign prev_entry_w = ctrl.new_entry;
        end
        else
        begin : g_inner
            assign prev_gt_w    = cell_gt[i-1];
            assign prev_entry_w = cell_entry[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_end
            assign next_entry_w = cell_entry[0];
        end
        else
        begin : g_mid
            assign next_entry_w = cell_entry[i+1];
        end

        spiq_cell u_cell (
            .clk        (clk),
            .ctrl       (ctrl),
            .occupied   (CNT_W'(i) < count_reg),
            .is_tail    (CNT_W'(i) == count_reg - CNT_W'(1)),
            .prev_gt    (prev_gt_w),
            .prev_entry (prev_entry_w),
            .next_entry (next_entry_w),
            .head_entry (cell_entry[0]),
            .entry      (cell_entry[i]),
            .gt         (cell_gt[i])
        );
    end

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        show_idx_next  = show_idx_reg;
        rsp_valid_next = rsp_valid_reg && !rsp.ready;
        rsp_data_next  = rsp_data_reg;

        if (accept)
        begin
            if (req_data.func == spiq_pkg::FUNC_INSERT)
            begin
                rsp_valid_next             = 1'b1;
                rsp_data_next.out_symbol   = '0;
                rsp_data_next.out_priority = '0;
                rsp_data_next.last         = 1'b1;
                if (full)
                begin
                    rsp_data_next.status    = spiq_pkg::STATUS_DROPPED;
                    rsp_data_next.occupancy = spiq_pkg::OCC_W'(count_reg);
                end
                else
                begin
                    count_next              = count_reg + CNT_W'(1);
                    rsp_data_next.status    = spiq_pkg::STATUS_OK;
                    rsp_data_next.occupancy = spiq_pkg::OCC_W'(count_reg + CNT_W'(1));
                end
            end
            else if (count_reg == '0)
            begin
                rsp_valid_next             = 1'b1;
                rsp_data_next.out_symbol   = '0;
                rsp_data_next.out_priority = '0;
                rsp_data_next.status       = spiq_pkg::STATUS_EMPTY;
                rsp_data_next.occupancy    = '0;
                rsp_data_next.last         = 1'b1;
            end
            else
            begin
                state_next    = ST_SHOW;
                show_idx_next = '0;
            end
        end
        else if (show_emit)
        begin
            // Cell 0 always holds the next entry in order while the row rotates.
            rsp_valid_next             = 1'b1;
            rsp_data_next.out_symbol   = cell_entry[0].sym;
            rsp_data_next.out_priority = cell_entry[0].pri;
            rsp_data_next.status       = spiq_pkg::STATUS_OK;
            rsp_data_next.occupancy    = spiq_pkg::OCC_W'(count_reg);
            rsp_data_next.last         = show_last;
            show_idx_next              = show_idx_reg + CNT_W'(1);
            if (show_last)
            begin
                state_next = ST_IDLE;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            show_idx_reg  <= '0;
            rsp_valid_reg <= 1'b0;
            rsp_data_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            show_idx_reg  <= show_idx_next;
            rsp_valid_reg <= rsp_valid_next;
            rsp_data_reg  <= rsp_data_next;
        end
    end

    assign rsp.valid   = rsp_valid_reg;
    assign rsp.payload = rsp_data_reg;

    // The entry count never passes the capacity.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    // A dropped insert leaves the count unchanged.
    a_drop_keeps_count: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && req_data.func == spiq_pkg::FUNC_INSERT && full) |=> $stable(count_reg))
        else $error("dropped insert changed the count");

    // An accepted insert with room grows the count by one.
    a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.insert |=> (count_reg == $past(count_reg) + CNT_W'(1)))
        else $error("accepted insert did not grow the count");

    // The count holds still for the whole of a show.
    a_show_count_stable: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SHOW) |=> $stable(count_reg))
        else $error("count changed during a show");

    // The final entry of a show returns the block to idle.
    a_show_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (show_emit && show_last) |=> (state_reg == ST_IDLE && rsp_valid_reg && rsp_data_reg.last))
        else $error("show did not end on its last entry");

endmodule

// File: dv/tb_sorted_insert_priority_queue.sv
// Testbench of the sorted-insert priority queue: random and directed requests against a predictor.
module tb_sorted_insert_priority_queue;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CAPACITY      = 16;
    localparam int CYCLE_LIMIT   = 300_000;
    localparam int RANDOM_COUNT  = 470;
    localparam int PHASE_LENGTH  = 59;
    localparam int DRAIN_CYCLES  = 40;
    localparam int REPORT_LIMIT  = 10;

    // Predicts the results of the queue and compares them with what the block delivers.
    // The predictor keeps its own sorted copy of the stored entries.
    class spiq_scoreboard;
        spiq_pkg::entry_t slots[CAPACITY];
        int unsigned      held;
        spiq_pkg::rsp_t   pending[$];
        int unsigned      mismatches;

        function new();
            held = 0;
            mismatches = 0;
        endfunction

        // Works out the results of one accepted request and updates the stored entries.
        function void note_request(spiq_pkg::req_t r);
            spiq_pkg::rsp_t e;
            int unsigned    pos;
            e = '0;
            if (r.func == spiq_pkg::FUNC_INSERT)
            begin
                e.last = 1'b1;
                if (held >= CAPACITY)
                begin
                    e.status    = spiq_pkg::STATUS_DROPPED;
                    e.occupancy = spiq_pkg::OCC_W'(held);
                end
                else
                begin
                    // The new entry goes after every entry of lower or equal priority.
                    pos = held;
                    for (int i = 0; i < held; i++)
                    begin
                        if (slots[i].pri > r.priority_req)
                        begin
                            pos = i;
                            break;
                        end
                    end
                    for (int i = held; i > pos; i--)
                    begin
                        slots[i] = slots[i - 1];
                    end
                    slots[pos].sym = r.symbol;
                    slots[pos].pri = r.priority_req;
                    held++;
                    e.status    = spiq_pkg::STATUS_OK;
                    e.occupancy = spiq_pkg::OCC_W'(held);
                end
                pending.push_back(e);
            end
            else if (held == 0)
            begin
                e.status    = spiq_pkg::STATUS_EMPTY;
                e.last      = 1'b1;
                pending.push_back(e);
            end
            else
            begin
                for (int i = 0; i < held; i++)
                begin
                    e.out_symbol   = slots[i].sym;
                    e.out_priority = slots[i].pri;
                    e.status       = spiq_pkg::STATUS_OK;
                    e.occupancy    = spiq_pkg::OCC_W'(held);
                    e.last         = (i == held - 1);
                    pending.push_back(e);
                end
            end
        endfunction

        // Compares one delivered result with the oldest expected one.
        function void check_result(spiq_pkg::rsp_t got);
            spiq_pkg::rsp_t exp;
            bit             bad;
            if (pending.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                begin
                    $display("%0t: unexpected result sym=%h pri=%h status=%0d occ=%0d last=%b",
                             $realtime, got.out_symbol, got.out_priority, got.status,
                             got.occupancy, got.last);
                end
                return;
            end
            exp = pending.pop_front();
            bad = 1'b0;
            if (got.out_symbol   !== exp.out_symbol)   bad = 1'b1;
            if (got.out_priority !== exp.out_priority) bad = 1'b1;
            if (got.status       !== exp.status)       bad = 1'b1;
            if (got.occupancy    !== exp.occupancy)    bad = 1'b1;
            if (got.last         !== exp.last)         bad = 1'b1;
            if (bad)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                begin
                    $display("%0t: result mismatch: expected sym=%h pri=%h status=%0d occ=%0d",
                             $realtime, exp.out_symbol, exp.out_priority, exp.status,
                             exp.occupancy, " last=%b", exp.last);
                    $display("%0t:                  actual sym=%h pri=%h status=%0d occ=%0d",
                             $realtime, got.out_symbol, got.out_priority, got.status,
                             got.occupancy, " last=%b", got.last);
                end
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;

    spiq_chan_if #(.payload_t(spiq_pkg::req_t)) req_if ();
    spiq_chan_if #(.payload_t(spiq_pkg::rsp_t)) rsp_if ();

    sorted_insert_priority_queue #(
        .CAPACITY (CAPACITY)
    ) uut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .rsp   (rsp_if)
    );

    spiq_scoreboard queue_model = new();

    // Percentages of cycles in which the sender holds back and the receiver stalls.
    // The main process changes them from one phase of the run to the next.
    int unsigned idle_pct  = 0;
    int unsigned stall_pct = 0;
    int unsigned cycles    = 0;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // The run ends with a failure if it takes far longer than the slowest correct run could.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("[sorted_insert_priority_queue] ERROR");
            $finish;
        end
    end

    // Result side: a result is taken at an edge where valid and ready were both high before
    // the edge. The ready for the next cycle is decided at the same edge, so in the phases
    // with stalling a show stream gets stalled now and then.
    initial
    begin
        rsp_if.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && rsp_if.valid === 1'b1 && rsp_if.ready)
            begin
                queue_model.check_result(rsp_if.payload);
            end
            rsp_if.ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    // Offers one request and returns at the edge where it is taken. Valid stays high after
    // acceptance; the next call either keeps it high or lowers it for an idle stretch, so
    // valid never gets two assignments in one time step.
    task automatic send_request(input spiq_pkg::req_t r);
        if ($urandom_range(0, 99) < idle_pct)
        begin
            req_if.valid <= 1'b0;
            do
            begin
                @(posedge clk);
            end while ($urandom_range(0, 99) < idle_pct);
        end
        req_if.valid   <= 1'b1;
        req_if.payload <= r;
        do
        begin
            @(posedge clk);
        end while (!req_if.ready);
        queue_model.note_request(r);
    endtask

    // Random priority: often a few small values so that ties are common, sometimes the
    // extremes, otherwise the whole range.
    function automatic logic [spiq_pkg::PRI_W-1:0] pick_priority();
        case ($urandom_range(0, 3))
            0: return spiq_pkg::PRI_W'($urandom_range(0, 3));
            1: return $urandom_range(0, 1) ? {spiq_pkg::PRI_W{1'b1}} : '0;
            default: return spiq_pkg::PRI_W'($urandom_range(0, 255));
        endcase
    endfunction

    initial
    begin
        spiq_pkg::req_t r;
        int             insert_pct;

        rst_n          = 1'b0;
        req_if.valid   = 1'b0;
        req_if.payload = '0;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part. A show on the empty queue gives the single empty result. Then
        // the priority and symbol extremes go in, with ties at both ends of the range and
        // entries in between, and a show checks that ties kept their arrival order.
        send_request('{spiq_pkg::FUNC_SHOW,   8'h00, 8'h00});
        send_request('{spiq_pkg::FUNC_INSERT, 8'h00, 8'h00});
        send_request('{spiq_pkg::FUNC_INSERT, 8'hFF, 8'hFF});
        send_request('{spiq_pkg::FUNC_INSERT, 8'hA5, 8'h00});
        send_request('{spiq_pkg::FUNC_INSERT, 8'h5A, 8'hFF});
        send_request('{spiq_pkg::FUNC_INSERT, 8'h3C, 8'h80});
        send_request('{spiq_pkg::FUNC_INSERT, 8'hC3, 8'h7F});
        send_request('{spiq_pkg::FUNC_SHOW,   8'hFF, 8'hFF});

        // Random part. There is no removal and reset comes only once, so the queue fills
        // over the first stretch of the run; shows see every occupancy on the way, and
        // after that inserts into the full queue are dropped. The idling pattern changes
        // every block of requests: none, sender idle, receiver stalling, both a little.
        for (int n = 0; n < RANDOM_COUNT; n++)
        begin
            if (n % PHASE_LENGTH == 0)
            begin
                case ((n / PHASE_LENGTH) % 4)
                    0:
                    begin
                        idle_pct = 0;
                        stall_pct = 0;
                    end
                    1:
                    begin
                        idle_pct = 58;
                        stall_pct = 0;
                    end
                    2:
                    begin
                        idle_pct = 0;
                        stall_pct = 58;
                    end
                    default:
                    begin
                        idle_pct = 7;
                        stall_pct = 7;
                    end
                endcase
            end
            insert_pct     = (queue_model.held < CAPACITY) ? 30 : 50;
            r.func         = ($urandom_range(0, 99) < insert_pct) ? spiq_pkg::FUNC_INSERT
                                                                  : spiq_pkg::FUNC_SHOW;
            r.symbol       = spiq_pkg::SYM_W'($urandom_range(0, 255));
            r.priority_req = pick_priority();
            send_request(r);
        end

        // The last request was taken at this edge, so valid drops at once.
        req_if.valid <= 1'b0;

        // Wait for every expected result, then a little longer to catch stray ones.
        while (queue_model.pending.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (queue_model.mismatches == 0 && queue_model.pending.size() == 0)
        begin
            $display("[sorted_insert_priority_queue] OK");
        end
        else
        begin
            $display("[sorted_insert_priority_queue] ERROR");
        end
        $finish;
    end

endmodule
